// ----- rtl/npc_pkg.sv -----
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the near plane polygon clipper.
// ----------------------------------------------------------------------------
package npc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_OF = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd4;

	localparam logic signed [31:0] ROW_X_RST  = 32'sd0;
	localparam logic signed [31:0] ROW_Y_RST  = 32'sd0;
	localparam logic signed [31:0] ROW_Z_RST  = 32'sd65536;
	localparam logic signed [31:0] ROW_OF_RST = 32'sd0;
	localparam logic [30:0]        NEAR_RST   = 31'd1966;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic               final_vertex;
	} vtx_t;

	typedef struct packed {
		logic signed [31:0] clip_x;
		logic signed [31:0] clip_y;
		logic signed [31:0] clip_z;
		logic               crossing_point;
		logic               end_marker;
		logic               polygon_valid;
		logic               run_last;
	} clip_t;

	// vertex with its view depth, as queued between front and back
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] d;
		logic               fin;
	} qent_t;

	typedef struct packed {
		logic signed [31:0] row_x;
		logic signed [31:0] row_y;
		logic signed [31:0] row_z;
		logic signed [31:0] row_of;
		logic [30:0]        near;
	} cfg_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_EDGE,
		B_START,
		B_DIVI,
		B_DIV,
		B_MUL,
		B_CROSS,
		B_NEXT,
		B_END,
		B_DONE
	} back_state_t;

endpackage

// ----- rtl/npc_ifs.sv -----
// ----------------------------------------------------------------------------
// npc_ifs
// Valid/ready channels for vertices in and clipped records out.
// ----------------------------------------------------------------------------
interface npc_vtx_if import npc_pkg::*; ();
	logic valid;
	logic ready;
	vtx_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface npc_clip_if import npc_pkg::*; ();
	logic  valid;
	logic  ready;
	clip_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/npc_front.sv -----
// ----------------------------------------------------------------------------
// npc_front
// Takes vertices, computes view depth (products, then saturating sum).
// ----------------------------------------------------------------------------
module npc_front import npc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	npc_vtx_if.sink          vin,
	output logic             push_v,
	output qent_t            push_d,
	input  logic             push_rdy
);

	localparam int SUM_W = 66;
	localparam logic signed [SUM_W-1:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [SUM_W-1:0] SAT_LO = -66'sd2147483648;

	logic               s1_v_q;
	logic signed [63:0] prod_x_s1, prod_y_s1, prod_z_s1;
	vtx_t               vtx_s1;
	logic signed [SUM_W-1:0] sum;
	logic signed [31:0] depth;

	assign vin.ready = !s1_v_q || push_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (vin.valid && vin.ready) begin
			s1_v_q <= 1'b1;
		end else if (push_rdy) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vin.valid && vin.ready) begin
			prod_x_s1 <= vin.data.vertex_x * cfg.row_x;
			prod_y_s1 <= vin.data.vertex_y * cfg.row_y;
			prod_z_s1 <= vin.data.vertex_z * cfg.row_z;
			vtx_s1    <= vin.data;
		end
	end

	// arithmetic shift is the floor of the fixed-point product
	always_comb begin
		sum = SUM_W'(prod_x_s1 >>> FRAC_BITS) + SUM_W'(prod_y_s1 >>> FRAC_BITS)
			+ SUM_W'(prod_z_s1 >>> FRAC_BITS) + SUM_W'(cfg.row_of);
		if (sum > SAT_HI) begin
			depth = 32'sh7fffffff;
		end else if (sum < SAT_LO) begin
			depth = 32'sh80000000;
		end else begin
			depth = sum[31:0];
		end
	end

	assign push_v     = s1_v_q;
	assign push_d.x   = vtx_s1.vertex_x;
	assign push_d.y   = vtx_s1.vertex_y;
	assign push_d.z   = vtx_s1.vertex_z;
	assign push_d.d   = depth;
	assign push_d.fin = vtx_s1.final_vertex;

endmodule

// ----- rtl/npc_queue.sv -----
// ----------------------------------------------------------------------------
// npc_queue
// Two-entry queue of depth-tagged vertices between front and back.
// ----------------------------------------------------------------------------
module npc_queue import npc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_v,
	input  qent_t push_d,
	output logic  push_rdy,
	output logic  pop_v,
	output qent_t pop_d,
	input  logic  pop
);

	qent_t      ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_rdy = cnt_q != 2'd2;
	assign pop_v    = cnt_q != 2'd0;
	assign pop_d    = ent_q[rd_q];
	assign do_push  = push_v && push_rdy;
	assign do_pop   = pop && pop_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_q] <= push_d;
	end

endmodule

// ----- rtl/npc_back.sv -----
// ----------------------------------------------------------------------------
// npc_back
// Walks the polygon edges, interpolates crossings, emits records.
// ----------------------------------------------------------------------------
module npc_back import npc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic [30:0] near,
	input  logic      head_v,
	input  qent_t     head,
	output logic      pop,
	npc_clip_if.source vout
);

	localparam int CW = $clog2(FRAC_BITS);
	localparam int PW = 35 + FRAC_BITS;
	localparam logic [FRAC_BITS:0] T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	back_state_t state_q, state_d;
	logic        sel_q;
	logic [1:0]  icnt_q, ecnt_q;
	qent_t       first_q, prev_q, e0, e1;
	logic [33:0] rem_q, den_q;
	logic [34:0] rem2;
	logic [FRAC_BITS:0] t_q;
	logic [CW-1:0] cnt_q;
	logic signed [PW-1:0] prod_q [3];
	logic signed [31:0] v0 [3], v1 [3], pt [3];
	logic signed [33:0] lim, d0, d1, num_r, den_r, num_a, den_a;
	logic        in0, in1, crosses, can_emit, emit, emit_vtx;
	clip_t       rec, out_q;
	logic        out_v_q;

	assign e0 = sel_q ? head : prev_q;
	assign e1 = sel_q ? first_q : head;
	assign v0[0] = e0.x;
	assign v0[1] = e0.y;
	assign v0[2] = e0.z;
	assign v1[0] = e1.x;
	assign v1[1] = e1.y;
	assign v1[2] = e1.z;

	assign lim     = 34'sd0 - 34'($signed({1'b0, near}));
	assign d0      = 34'($signed(e0.d));
	assign d1      = 34'($signed(e1.d));
	assign in0     = d0 <= lim;
	assign in1     = d1 <= lim;
	assign crosses = in0 != in1;
	assign num_r   = lim - d0;
	assign den_r   = d1 - d0;
	assign num_a   = den_r < 0 ? -num_r : num_r;
	assign den_a   = den_r < 0 ? -den_r : den_r;
	assign rem2    = {rem_q, 1'b0};

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			pt[j] = 32'(PW'(v0[j]) + (prod_q[j] >>> FRAC_BITS));
		end
	end

	assign can_emit = !out_v_q || vout.ready;

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		emit_vtx = 1'b0;
		pop      = 1'b0;
		rec      = '0;
		case (state_q)
			B_IDLE: begin
				if (head_v) begin
					if (head.fin && icnt_q < 2'd2) begin
						state_d = B_END;
					end else if (icnt_q == 2'd0) begin
						state_d = B_DONE;
					end else begin
						state_d = B_EDGE;
					end
				end
			end
			B_EDGE: begin
				if (in0) begin
					state_d = B_START;
				end else if (crosses) begin
					state_d = B_DIVI;
				end else begin
					state_d = B_NEXT;
				end
			end
			B_START: begin
				if (can_emit) begin
					emit     = 1'b1;
					emit_vtx = 1'b1;
					rec.clip_x   = e0.x;
					rec.clip_y   = e0.y;
					rec.clip_z   = e0.z;
					rec.run_last = !head.fin && !crosses;
					state_d = crosses ? B_DIVI : B_NEXT;
				end
			end
			B_DIVI: begin
				if (num_a <= 0 || num_a >= den_a) begin
					state_d = B_MUL;
				end else begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (cnt_q == CW'(FRAC_BITS - 1)) state_d = B_MUL;
			end
			B_MUL: begin
				state_d = B_CROSS;
			end
			B_CROSS: begin
				if (can_emit) begin
					emit     = 1'b1;
					emit_vtx = 1'b1;
					rec.clip_x         = pt[0];
					rec.clip_y         = pt[1];
					rec.clip_z         = pt[2];
					rec.crossing_point = 1'b1;
					rec.run_last       = !head.fin;
					state_d = B_NEXT;
				end
			end
			B_NEXT: begin
				if (head.fin && !sel_q) begin
					state_d = B_EDGE;
				end else if (head.fin) begin
					state_d = B_END;
				end else begin
					state_d = B_DONE;
				end
			end
			B_END: begin
				if (can_emit) begin
					emit = 1'b1;
					rec.end_marker    = 1'b1;
					rec.polygon_valid = ecnt_q == 2'd3;
					rec.run_last      = 1'b1;
					state_d = B_DONE;
				end
			end
			B_DONE: begin
				pop     = 1'b1;
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			sel_q   <= 1'b0;
			icnt_q  <= 2'd0;
			ecnt_q  <= 2'd0;
			out_v_q <= 1'b0;
			first_q <= '0;
			prev_q  <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (vout.ready) begin
				out_v_q <= 1'b0;
			end
			if (emit_vtx && ecnt_q != 2'd3) ecnt_q <= ecnt_q + 2'd1;
			case (state_q)
				B_IDLE: begin
					sel_q <= 1'b0;
					if (head_v && !head.fin && icnt_q == 2'd0) first_q <= head;
				end
				B_NEXT: begin
					if (head.fin && !sel_q) sel_q <= 1'b1;
				end
				B_DONE: begin
					prev_q <= head;
					if (head.fin) begin
						icnt_q <= 2'd0;
						ecnt_q <= 2'd0;
					end else if (icnt_q != 2'd3) begin
						icnt_q <= icnt_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// serial restoring divider, one quotient bit per cycle, then the lerp products
	always_ff @(posedge clk) begin
		if (emit) out_q <= rec;
		case (state_q)
			B_DIVI: begin
				rem_q <= num_a[33:0];
				den_q <= den_a[33:0];
				cnt_q <= '0;
				if (num_a <= 0) begin
					t_q <= '0;
				end else if (num_a >= den_a) begin
					t_q <= T_ONE;
				end else begin
					t_q <= '0;
				end
			end
			B_DIV: begin
				cnt_q <= cnt_q + CW'(1);
				if (rem2 >= {1'b0, den_q}) begin
					rem_q <= 34'(rem2 - {1'b0, den_q});
					t_q   <= {t_q[FRAC_BITS-1:0], 1'b1};
				end else begin
					rem_q <= rem2[33:0];
					t_q   <= {t_q[FRAC_BITS-1:0], 1'b0};
				end
			end
			B_MUL: begin
				for (int j = 0; j < 3; j++) begin
					prod_q[j] <= (PW'(v1[j]) - PW'(v0[j])) * PW'($signed({1'b0, t_q}));
				end
			end
			default: ;
		endcase
	end

	assign vout.valid = out_v_q;
	assign vout.data  = out_q;

endmodule

// ----- rtl/near_plane_polygon_clipper_unit.sv -----
// ----------------------------------------------------------------------------
// near_plane_polygon_clipper_unit
// Single-plane polygon clipper against the view-space near plane.
// ----------------------------------------------------------------------------
// Vertices enter a depth front end (three parallel products, then a saturating
// sum) and wait in a two-entry queue; the edge walker behind it handles one
// vertex at a time. Every crossing runs the one-bit-per-cycle divider that
// forms the interpolation fraction; the division is skipped when the fraction
// clamps. Results leave through a registered output, so a stalled sink holds
// back only the edge walker while the front end fills.
module near_plane_polygon_clipper_unit import npc_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	npc_vtx_if.sink               vin,
	npc_clip_if.source            vout
);

	cfg_t  cfg_q;
	logic  push_v, push_rdy, pop_v, pop;
	qent_t push_d, pop_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_x  <= ROW_X_RST;
			cfg_q.row_y  <= ROW_Y_RST;
			cfg_q.row_z  <= ROW_Z_RST;
			cfg_q.row_of <= ROW_OF_RST;
			cfg_q.near   <= NEAR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_X:  cfg_q.row_x  <= cfg_wdata;
				REG_ROW_Y:  cfg_q.row_y  <= cfg_wdata;
				REG_ROW_Z:  cfg_q.row_z  <= cfg_wdata;
				REG_ROW_OF: cfg_q.row_of <= cfg_wdata;
				REG_NEAR:   cfg_q.near   <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	npc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.vin      (vin),
		.push_v   (push_v),
		.push_d   (push_d),
		.push_rdy (push_rdy)
	);

	npc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_v   (push_v),
		.push_d   (push_d),
		.push_rdy (push_rdy),
		.pop_v    (pop_v),
		.pop_d    (pop_d),
		.pop      (pop)
	);

	npc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.near   (cfg_q.near),
		.head_v (pop_v),
		.head   (pop_d),
		.pop    (pop),
		.vout   (vout)
	);

endmodule

// ----- verif/tb_near_plane_polygon_clipper_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_near_plane_polygon_clipper_unit
// Streams polygons through the near plane clipper under several depth-row and
// near-plane settings, predicts every clipped record in a scoreboard and
// compares field by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_near_plane_polygon_clipper_unit;
	import npc_pkg::*;

	localparam int FB          = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 120;

	class clip_scoreboard;
		longint row_x, row_y, row_z, row_of, near_d;
		longint first_v[3], prev_v[3];
		longint first_d, prev_d;
		int     in_cnt, em_cnt;
		clip_t  pending[$];
		int     errors;

		function new();
			errors = 0;
			row_x = ROW_X_RST; row_y = ROW_Y_RST; row_z = ROW_Z_RST;
			row_of = ROW_OF_RST; near_d = NEAR_RST;
			for (int j = 0; j < 3; j++) begin
				first_v[j] = 0; prev_v[j] = 0;
			end
			first_d = 0; prev_d = 0; in_cnt = 0; em_cnt = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] w);
			case (idx)
				REG_ROW_X:  row_x = longint'($signed(w));
				REG_ROW_Y:  row_y = longint'($signed(w));
				REG_ROW_Z:  row_z = longint'($signed(w));
				REG_ROW_OF: row_of = longint'($signed(w));
				REG_NEAR:   near_d = longint'({33'd0, w[30:0]});
				default: ;
			endcase
		endfunction

		function longint view_depth(longint p[3]);
			longint s;
			s = ((row_x * p[0]) >>> FB) + ((row_y * p[1]) >>> FB)
				+ ((row_z * p[2]) >>> FB) + row_of;
			if (s > 64'sd2147483647) s = 64'sd2147483647;
			if (s < -64'sd2147483648) s = -64'sd2147483648;
			return s;
		endfunction

		function void emit(longint p[3], bit xing, bit endm, bit pvalid);
			clip_t r;
			r.clip_x = p[0][31:0];
			r.clip_y = p[1][31:0];
			r.clip_z = p[2][31:0];
			r.crossing_point = xing;
			r.end_marker = endm;
			r.polygon_valid = pvalid;
			r.run_last = 1'b0;
			pending = {pending, r};
			if (!endm && em_cnt < 3) em_cnt++;
		endfunction

		function void walk_edge(longint v0[3], longint d0, longint v1[3], longint d1);
			longint lim, num, den, t;
			longint p[3];
			bit in0, in1;
			lim = -near_d;
			in0 = d0 <= lim;
			in1 = d1 <= lim;
			if (in0) emit(v0, 0, 0, 0);
			if (in0 != in1) begin
				num = lim - d0;
				den = d1 - d0;
				if (den < 0) begin
					den = -den; num = -num;
				end
				if (num <= 0 || den == 0) t = 0;
				else if (num >= den) t = longint'(1) << FB;
				else t = (num << FB) / den;
				for (int j = 0; j < 3; j++)
					p[j] = v0[j] + (((v1[j] - v0[j]) * t) >>> FB);
				emit(p, 1, 0, 0);
			end
		endfunction

		function void note_vertex(vtx_t v);
			longint cur[3];
			longint zero_v[3];
			longint d;
			int start;
			start = pending.size();
			cur[0] = longint'(v.vertex_x);
			cur[1] = longint'(v.vertex_y);
			cur[2] = longint'(v.vertex_z);
			for (int j = 0; j < 3; j++) zero_v[j] = 0;
			d = view_depth(cur);
			if (v.final_vertex && in_cnt < 2) begin
				emit(zero_v, 0, 1, 0);
			end else begin
				if (in_cnt == 0) begin
					first_v = cur;
					first_d = d;
				end else begin
					walk_edge(prev_v, prev_d, cur, d);
				end
				if (v.final_vertex) begin
					walk_edge(cur, d, first_v, first_d);
					emit(zero_v, 0, 1, em_cnt >= 3);
				end
			end
			prev_v = cur;
			prev_d = d;
			if (v.final_vertex) begin
				in_cnt = 0; em_cnt = 0;
			end else if (in_cnt < 3) begin
				in_cnt++;
			end
			if (pending.size() > start) pending[$].run_last = 1'b1;
		endfunction

		function void check(clip_t got);
			clip_t exp;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected record %h", $time, got);
				return;
			end
			exp = pending.pop_front();
			if (exp !== got) begin
				errors++;
				if (exp.clip_x !== got.clip_x)
					$display("%0t: clip_x exp %h got %h", $time, exp.clip_x, got.clip_x);
				if (exp.clip_y !== got.clip_y)
					$display("%0t: clip_y exp %h got %h", $time, exp.clip_y, got.clip_y);
				if (exp.clip_z !== got.clip_z)
					$display("%0t: clip_z exp %h got %h", $time, exp.clip_z, got.clip_z);
				if (exp.crossing_point !== got.crossing_point)
					$display("%0t: crossing_point exp %b got %b", $time,
						exp.crossing_point, got.crossing_point);
				if (exp.end_marker !== got.end_marker)
					$display("%0t: end_marker exp %b got %b", $time,
						exp.end_marker, got.end_marker);
				if (exp.polygon_valid !== got.polygon_valid)
					$display("%0t: polygon_valid exp %b got %b", $time,
						exp.polygon_valid, got.polygon_valid);
				if (exp.run_last !== got.run_last)
					$display("%0t: run_last exp %b got %b", $time,
						exp.run_last, got.run_last);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    cycles;
	int                    stall_mode;

	npc_vtx_if  vin ();
	npc_clip_if vout ();

	clip_scoreboard sb;

	near_plane_polygon_clipper_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.vin       (vin.sink),
		.vout      (vout.source)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		vin.valid = 1'b0;
		vin.data = '0;
		vout.ready = 1'b0;
		stall_mode = 0;
		sb = new();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end
	initial cycles = 0;

	// result side: checks each transfer, then picks ready for the next edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (vout.valid && vout.ready) sb.check(vout.data);
			if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: vout.ready <= 1'b1;
				1: vout.ready <= ($urandom_range(0, 3) != 0);
				2: vout.ready <= ($urandom_range(0, 1) != 0);
				default: vout.ready <= ($urandom_range(0, 19) == 0);
			endcase
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_vertex(vtx_t v);
		int gap;
		vin.valid <= 1'b1;
		vin.data <= v;
		@(posedge clk);
		while (!vin.ready) @(posedge clk);
		sb.note_vertex(v);
		gap = pick_gap();
		if (gap > 0) begin
			vin.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		vin.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] w);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, w);
	endtask

	task automatic load_setting(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
		logic [31:0] ro, logic [31:0] nr);
		write_reg(REG_ROW_X, rx);
		write_reg(REG_ROW_Y, ry);
		write_reg(REG_ROW_Z, rz);
		write_reg(REG_ROW_OF, ro);
		write_reg(REG_NEAR, nr);
		@(posedge clk);
	endtask

	function automatic vtx_t mk(int x, int y, int z, bit fin);
		vtx_t v;
		v.vertex_x = x; v.vertex_y = y; v.vertex_z = z; v.final_vertex = fin;
		return v;
	endfunction

	// coordinates clustered near the plane so edges cross often
	function automatic logic [31:0] near_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return $urandom();
		if (r < 3) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
	endfunction

	task automatic random_polygons(int n_items);
		int sent;
		int nv;
		vtx_t v;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) nv = $urandom_range(1, 2);
			else nv = $urandom_range(3, 7);
			for (int k = 0; k < nv; k++) begin
				v.vertex_x = near_coord();
				v.vertex_y = near_coord();
				v.vertex_z = near_coord();
				v.final_vertex = (k == nv - 1);
				// broken sequence now and then: an early final marker
				if ($urandom_range(0, 29) == 0) v.final_vertex = 1'b1;
				send_vertex(v);
				sent++;
				if (v.final_vertex) break;
			end
		end
		// a lone final vertex at the end: an end marker for an empty polygon
		send_vertex(mk(0, 0, 0, 1'b1));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset setting, depth = z, inside means z <= -near
		send_vertex(mk(0, 0, 0, 1'b1));
		send_vertex(mk(1, 1, -70000, 1'b0));
		send_vertex(mk(2, 2, -70000, 1'b1));
		send_vertex(mk(0, 0, -65536, 1'b0));
		send_vertex(mk(65536, 0, -65536, 1'b0));
		send_vertex(mk(0, 65536, -65536, 1'b1));
		send_vertex(mk(0, 0, 65536, 1'b0));
		send_vertex(mk(65536, 0, 65536, 1'b0));
		send_vertex(mk(0, 65536, 65536, 1'b1));
		send_vertex(mk(0, 0, -65536, 1'b0));
		send_vertex(mk(65536, 0, 65536, 1'b0));
		send_vertex(mk(0, 65536, -1966, 1'b0));
		send_vertex(mk(-65536, 0, -1965, 1'b0));
		send_vertex(mk(100, 100, 0, 1'b1));
		send_vertex(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 1'b0));
		send_vertex(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0));
		send_vertex(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1));
		wait_idle();

		load_setting(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
		send_vertex(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 1'b0));
		send_vertex(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0));
		send_vertex(mk(1, -1, 0, 1'b0));
		send_vertex(mk(0, 0, 0, 1'b1));
		wait_idle();

		random_polygons(80);
		wait_idle();

		load_setting(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h7fffffff);
		random_polygons(40);
		wait_idle();

		load_setting(32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
		random_polygons(80);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			load_setting($urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
				$urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
				$urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
				$urandom_range(0, 32'h0000_4000) - 32'h0000_2000,
				$urandom_range(0, 32'h0000_1000));
			random_polygons(60);
			wait_idle();
		end

		load_setting($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		random_polygons(30);
		wait_idle();

		if (sb.pending.size() == 0 && sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
